// ----- src/i2c_master_byte_engine_core_assert.svh -----
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Shared property forms for the checker, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    localparam int TICK_WIDTH = 16;
    localparam int STEP_WIDTH = 6;
    localparam int DATA_WIDTH = 8;
    localparam int PADDR_WIDTH = 3;

    localparam logic [TICK_WIDTH-1:0] UNIT_RESET = TICK_WIDTH'(1000);

    localparam logic [STEP_WIDTH-1:0] START_UNITS = STEP_WIDTH'(5);
    localparam logic [STEP_WIDTH-1:0] STOP_UNITS  = STEP_WIDTH'(4);
    localparam logic [STEP_WIDTH-1:0] BYTE_UNITS  = STEP_WIDTH'(36);
    localparam logic [STEP_WIDTH-1:0] BIT_UNITS   = STEP_WIDTH'(32);
    localparam logic [STEP_WIDTH-1:0] ACK_DRIVE_UNIT  = STEP_WIDTH'(33);
    localparam logic [STEP_WIDTH-1:0] ACK_SAMPLE_UNIT = STEP_WIDTH'(35);

    localparam logic [0:0] REG_TICKS_PER_UNIT = 1'b0;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        PH_SETUP = 2'd0,
        PH_RISE  = 2'd1,
        PH_HIGH  = 2'd2,
        PH_FALL  = 2'd3
    } phase_t;

    typedef struct packed {
        logic                  cmd_valid;
        logic [1:0]            req_type;
        logic [DATA_WIDTH-1:0] write_data;
        logic                  send_ack;
        logic                  sda_in;
    } in_item_t;

    typedef struct packed {
        logic                  scl_out;
        logic                  sda_out;
        logic                  sda_drive;
        logic                  busy_res;
        logic                  done_res;
        logic [DATA_WIDTH-1:0] read_data;
        logic                  ack_seen;
    } out_item_t;

    function automatic logic [STEP_WIDTH-1:0] total_units(input cmd_e_t cmd);
        logic [STEP_WIDTH-1:0] n;
        unique case (cmd)
            CMD_START: n = START_UNITS;
            CMD_STOP:  n = STOP_UNITS;
            default:   n = BYTE_UNITS;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- src/i2cm_apb_regs.sv -----
// ----------------------------------------------------------------------------
// i2cm_apb_regs
// APB register file: holds the tick count of one bus timing unit.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_apb_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [i2cm_pkg::PADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [i2cm_pkg::TICK_WIDTH-1:0]     ticks_per_unit
);
    import i2cm_pkg::*;

    logic [TICK_WIDTH-1:0] ticks_reg;
    logic                  sel_ticks;
    logic                  wr_en;

    assign pready    = 1'b1;
    assign sel_ticks = (paddr[2] == REG_TICKS_PER_UNIT);
    assign wr_en     = psel && penable && pwrite && pready && sel_ticks;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= UNIT_RESET;
        end
        else if (wr_en)
        begin
            ticks_reg <= pwdata[TICK_WIDTH-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_ticks)
        begin
            prdata = {{(32-TICK_WIDTH){1'b0}}, ticks_reg};
        end
    end

    assign ticks_per_unit = ticks_reg;

endmodule

`default_nettype wire

// ----- src/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances unit timing and pin levels by one tick per item.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step_en,
    input  wire i2cm_pkg::in_item_t         item,
    input  wire logic [i2cm_pkg::TICK_WIDTH-1:0] ticks_per_unit,
    output i2cm_pkg::out_item_t             result
);
    import i2cm_pkg::*;

    cmd_e_t                cmd_reg, cmd_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [STEP_WIDTH-1:0] step_reg, step_next;
    logic [DATA_WIDTH-1:0] shift_reg, shift_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  drive_reg, drive_next;
    logic                  busy_reg, busy_next;
    logic                  ack_level_reg, ack_level_next;
    logic [DATA_WIDTH-1:0] last_read_reg, last_read_next;
    logic                  last_ack_reg, last_ack_next;

    logic [TICK_WIDTH:0]   unit_len;
    logic [TICK_WIDTH:0]   tick_inc;
    logic [STEP_WIDTH-1:0] step_inc;
    logic [STEP_WIDTH-1:0] act_unit;
    logic [STEP_WIDTH-1:0] read_unit;
    logic                  act_en;
    logic                  done;

    always_comb
    begin
        cmd_next       = cmd_reg;
        tick_next      = tick_reg;
        step_next      = step_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drive_next     = drive_reg;
        busy_next      = busy_reg;
        ack_level_next = ack_level_reg;
        last_read_next = last_read_reg;
        last_ack_next  = last_ack_reg;
        done           = 1'b0;
        act_en         = 1'b0;
        act_unit       = '0;

        unit_len  = (ticks_per_unit == '0) ? (TICK_WIDTH+1)'(1) : {1'b0, ticks_per_unit};
        tick_inc  = {1'b0, tick_reg} + (TICK_WIDTH+1)'(1);
        step_inc  = step_reg + STEP_WIDTH'(1);

        if (busy_reg)
        begin
            if (tick_inc >= unit_len)
            begin
                tick_next = '0;
                step_next = step_inc;
                if (step_inc >= total_units(cmd_reg))
                begin
                    if (cmd_reg == CMD_WRITE)
                    begin
                        sda_next   = 1'b1;
                        drive_next = 1'b1;
                    end
                    else if (cmd_reg == CMD_READ)
                    begin
                        last_read_next = shift_reg;
                    end
                    busy_next = 1'b0;
                    done      = 1'b1;
                end
                else
                begin
                    act_en   = 1'b1;
                    act_unit = step_inc;
                end
            end
            else
            begin
                tick_next = tick_inc[TICK_WIDTH-1:0];
            end
        end
        else if (item.cmd_valid)
        begin
            cmd_next   = cmd_e_t'(item.req_type);
            tick_next  = '0;
            step_next  = '0;
            shift_next = (cmd_e_t'(item.req_type) == CMD_WRITE) ? item.write_data : '0;
            if (cmd_e_t'(item.req_type) == CMD_READ)
            begin
                ack_level_next = item.send_ack;
            end
            busy_next = 1'b1;
            act_en    = 1'b1;
        end

        read_unit = act_unit - STEP_WIDTH'(1);

        if (act_en)
        begin
            unique case (cmd_next)
                CMD_START:
                begin
                    if (act_unit == STEP_WIDTH'(0))
                    begin
                        sda_next   = 1'b1;
                        drive_next = 1'b1;
                    end
                    else if (act_unit == STEP_WIDTH'(1)) scl_next = 1'b1;
                    else if (act_unit == STEP_WIDTH'(2)) sda_next = 1'b0;
                    else if (act_unit == STEP_WIDTH'(3)) scl_next = 1'b0;
                end
                CMD_STOP:
                begin
                    if (act_unit == STEP_WIDTH'(0))
                    begin
                        sda_next   = 1'b0;
                        drive_next = 1'b1;
                    end
                    else if (act_unit == STEP_WIDTH'(1)) scl_next = 1'b1;
                    else if (act_unit == STEP_WIDTH'(2)) sda_next = 1'b1;
                end
                CMD_WRITE:
                begin
                    if (act_unit < BIT_UNITS)
                    begin
                        case (phase_t'(act_unit[1:0]))
                            PH_SETUP:
                            begin
                                sda_next   = shift_next[DATA_WIDTH-1];
                                drive_next = 1'b1;
                            end
                            PH_RISE: scl_next = 1'b1;
                            PH_FALL:
                            begin
                                scl_next   = 1'b0;
                                shift_next = {shift_next[DATA_WIDTH-2:0], 1'b0};
                            end
                            default: ;
                        endcase
                    end
                    else if (act_unit == ACK_DRIVE_UNIT)
                    begin
                        drive_next = 1'b0;
                        scl_next   = 1'b1;
                    end
                    else if (act_unit == ACK_SAMPLE_UNIT)
                    begin
                        last_ack_next = item.sda_in;
                        scl_next      = 1'b0;
                    end
                end
                CMD_READ:
                begin
                    if (act_unit == STEP_WIDTH'(0))
                    begin
                        drive_next = 1'b0;
                    end
                    else if (act_unit <= BIT_UNITS)
                    begin
                        case (phase_t'(read_unit[1:0]))
                            PH_SETUP: scl_next = 1'b1;
                            PH_HIGH:
                            begin
                                shift_next = {shift_next[DATA_WIDTH-2:0], item.sda_in};
                                scl_next   = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    else if (act_unit == ACK_DRIVE_UNIT)
                    begin
                        sda_next   = ack_level_next;
                        drive_next = 1'b1;
                        scl_next   = 1'b1;
                    end
                    else if (act_unit == ACK_SAMPLE_UNIT)
                    begin
                        scl_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        result.scl_out   = scl_next;
        result.sda_out   = sda_next;
        result.sda_drive = drive_next;
        result.busy_res  = busy_next;
        result.done_res  = done;
        result.read_data = last_read_next;
        result.ack_seen  = last_ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_START;
            tick_reg      <= '0;
            step_reg      <= '0;
            shift_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b1;
            busy_reg      <= 1'b0;
            ack_level_reg <= 1'b1;
            last_read_reg <= '0;
            last_ack_reg  <= 1'b1;
        end
        else if (step_en)
        begin
            cmd_reg       <= cmd_next;
            tick_reg      <= tick_next;
            step_reg      <= step_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drive_reg     <= drive_next;
            busy_reg      <= busy_next;
            ack_level_reg <= ack_level_next;
            last_read_reg <= last_read_next;
            last_ack_reg  <= last_ack_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/i2c_master_byte_engine_core.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// I2C master pin sequencer: one tick item in, one pin/status result out.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   in_item_t
//   res       out        res_valid/res_stall   out_item_t
//   apb       in         psel/penable/pready   ticks_per_unit
//
// One item per cycle while no result stalls; each item passes the input
// register, then the sequencer state update into the result register.
// Reset clears the sequencer to idle with SCL high and SDA driven high.
// A stalled result holds; the input register keeps taking one more item,
// then req_stall rises until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire i2cm_pkg::in_item_t               req,
    output logic                                  res_valid,
    input  wire logic                             res_stall,
    output i2cm_pkg::out_item_t                   res,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [i2cm_pkg::PADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import i2cm_pkg::*;

    logic                  in_valid_reg;
    in_item_t              in_item_reg;
    logic                  res_valid_reg;
    out_item_t             res_item_reg;
    logic                  out_free;
    logic                  advance;
    logic                  take_in;
    logic [TICK_WIDTH-1:0] ticks_per_unit;
    out_item_t             seq_result;

    i2cm_apb_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .ticks_per_unit (ticks_per_unit)
    );

    i2cm_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (advance),
        .item           (in_item_reg),
        .ticks_per_unit (ticks_per_unit),
        .result         (seq_result)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign advance   = in_valid_reg && out_free;
    assign req_stall = in_valid_reg && !out_free;
    assign take_in   = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg <= req;
        end
        if (advance)
        begin
            res_item_reg <= seq_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_item_reg;

endmodule

`default_nettype wire

// ----- src/i2cm_checker.sv -----
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result channel of the byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_core_assert.svh"

module i2cm_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                res_valid,
    input wire logic                res_stall,
    input wire i2cm_pkg::out_item_t res
);
    import i2cm_pkg::*;

    `I2CM_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
    `I2CM_ASSERT_NOW(a_done_idle, res_valid && res.done_res, !res.busy_res, "done while still busy")
    `I2CM_ASSERT_NOW(a_idle_drive, res_valid && !res.busy_res, res.sda_drive, "SDA released while idle")
    `I2CM_ASSERT_NEXT(a_done_single, res_valid && res.done_res && !res_stall, !(res_valid && res.done_res), "done on back-to-back transfers")

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

// ----- tb/sv/i2c_master_byte_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core_tb
// Drives one bus tick per transfer into the I2C byte engine and checks every
// pin/status result against a cycle model of the sequencer kept in this
// bench. A directed table covers reset levels, every command, ignored
// commands and the shortest unit lengths. Random command streams follow at
// several unit lengths, under three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_core_tb;

    import i2cm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int SEGMENT_ITEMS  = 50;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PLAN_ROWS      = 23;
    localparam int HOLD_ITEMS     = 100;

    localparam logic [PADDR_WIDTH-1:0] UNIT_ADDR = PADDR_WIDTH'(4 * REG_TICKS_PER_UNIT);

    localparam out_item_t RESET_PINS = '{scl_out: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
                                         busy_res: 1'b0, done_res: 1'b0, read_data: 8'h00,
                                         ack_seen: 1'b1};
    localparam out_item_t START_PINS = '{scl_out: 1'b1, sda_out: 1'b1, sda_drive: 1'b1,
                                         busy_res: 1'b1, done_res: 1'b0, read_data: 8'h00,
                                         ack_seen: 1'b1};

    typedef enum logic [1:0] {
        ROW_TICK     = 2'd0,
        ROW_SET_UNIT = 2'd1,
        ROW_DRAIN    = 2'd2
    } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        in_item_t    tick;
        logic [15:0] unit_ticks;
        logic        typed;
        out_item_t   want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    in_item_t    req = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    out_item_t   res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          send_gap_pct = 17;
    int          recv_stall_pct = 59;
    int unsigned bad_fields = 0;
    int unsigned ticks_sent = 0;
    int unsigned quiet_cycles = 0;
    out_item_t   pin_states_q [$];
    plan_row_t   plan_rows [PLAN_ROWS];

    // sequencer model state
    logic [15:0]         unit_ticks = UNIT_RESET;
    cmd_e_t              cur_cmd = CMD_START;
    int unsigned         tick_cnt = 0;
    logic [STEP_WIDTH-1:0] step = '0;
    logic [7:0]          shreg = '0;
    logic                p_scl = 1'b1;
    logic                p_sda = 1'b1;
    logic                p_drv = 1'b1;
    logic                seq_busy = 1'b0;
    logic                ack_lvl = 1'b1;
    logic [7:0]          rd_byte = '0;
    logic                ack_bit = 1'b1;

    i2c_master_byte_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic in_item_t noise_tick(input int cmd_pct);
        in_item_t it;
        it.cmd_valid  = roll(cmd_pct);
        it.req_type   = 2'($urandom_range(3));
        it.write_data = 8'($urandom);
        it.send_ack   = 1'($urandom);
        it.sda_in     = 1'($urandom);
        return it;
    endfunction

    function automatic void unit_pins(input logic [STEP_WIDTH-1:0] u, input logic sda);
        phase_t ph;
        ph = phase_t'(u[1:0]);
        case (cur_cmd)
            CMD_START:
            begin
                case (u)
                    0: begin p_sda = 1'b1; p_drv = 1'b1; end
                    1: p_scl = 1'b1;
                    2: p_sda = 1'b0;
                    3: p_scl = 1'b0;
                    default: ;
                endcase
            end
            CMD_STOP:
            begin
                case (u)
                    0: begin p_sda = 1'b0; p_drv = 1'b1; end
                    1: p_scl = 1'b1;
                    2: p_sda = 1'b1;
                    default: ;
                endcase
            end
            CMD_WRITE:
            begin
                if (u < BIT_UNITS)
                begin
                    case (ph)
                        PH_SETUP: begin p_sda = shreg[7]; p_drv = 1'b1; end
                        PH_RISE:  p_scl = 1'b1;
                        PH_FALL:  begin p_scl = 1'b0; shreg = {shreg[6:0], 1'b0}; end
                        default: ;
                    endcase
                end
                else if (u == ACK_DRIVE_UNIT)
                begin
                    p_drv = 1'b0;
                    p_scl = 1'b1;
                end
                else if (u == ACK_SAMPLE_UNIT)
                begin
                    ack_bit = sda;
                    p_scl = 1'b0;
                end
            end
            default:
            begin
                if (u == 0)
                    p_drv = 1'b0;
                else if (u <= BIT_UNITS)
                begin
                    case (ph)
                        PH_RISE: p_scl = 1'b1;
                        PH_FALL: begin shreg = {shreg[6:0], sda}; p_scl = 1'b0; end
                        default: ;
                    endcase
                end
                else if (u == ACK_DRIVE_UNIT)
                begin
                    p_sda = ack_lvl;
                    p_drv = 1'b1;
                    p_scl = 1'b1;
                end
                else if (u == ACK_SAMPLE_UNIT)
                    p_scl = 1'b0;
            end
        endcase
    endfunction

    function automatic out_item_t pins_after_tick(input in_item_t it);
        out_item_t             o;
        int unsigned           unit_len;
        logic [STEP_WIDTH-1:0] units;
        logic                  fin;
        fin = 1'b0;
        unit_len = (unit_ticks == 0) ? 1 : 32'(unit_ticks);
        case (cur_cmd)
            CMD_START: units = START_UNITS;
            CMD_STOP:  units = STOP_UNITS;
            default:   units = BYTE_UNITS;
        endcase
        if (seq_busy)
        begin
            tick_cnt++;
            if (tick_cnt >= unit_len)
            begin
                tick_cnt = 0;
                step = step + 1'b1;
                if (step >= units)
                begin
                    if (cur_cmd == CMD_WRITE)
                    begin
                        p_sda = 1'b1;
                        p_drv = 1'b1;
                    end
                    else if (cur_cmd == CMD_READ)
                        rd_byte = shreg;
                    seq_busy = 1'b0;
                    fin = 1'b1;
                end
                else
                    unit_pins(step, it.sda_in);
            end
        end
        else if (it.cmd_valid)
        begin
            cur_cmd = cmd_e_t'(it.req_type);
            tick_cnt = 0;
            step = '0;
            shreg = (cur_cmd == CMD_WRITE) ? it.write_data : 8'h00;
            if (cur_cmd == CMD_READ)
                ack_lvl = it.send_ack;
            seq_busy = 1'b1;
            unit_pins('0, it.sda_in);
        end
        o.scl_out   = p_scl;
        o.sda_out   = p_sda;
        o.sda_drive = p_drv;
        o.busy_res  = seq_busy;
        o.done_res  = fin;
        o.read_data = rd_byte;
        o.ack_seen  = ack_bit;
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            bad_fields++;
        end
    endfunction

    task automatic push_tick(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t predicted;
        while (roll(send_gap_pct))
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = pins_after_tick(it);
        pin_states_q.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic drain_command();
        while (seq_busy)
            push_tick(noise_tick(10), 1'b0, '0);
    endtask

    task automatic set_unit_ticks(input logic [15:0] value);
        req_valid <= 1'b0;
        while (pin_states_q.size() != 0)
            @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= UNIT_ADDR;
        pwdata <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        unit_ticks = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("ticks_per_unit", {16'h0000, unit_ticks}, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        res_stall <= roll(recv_stall_pct);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pin_states_q.size() == 0)
            begin
                $error("result with no pending tick: %p", res);
                bad_fields++;
            end
            else
            begin
                want = pin_states_q.pop_front();
                check_field("scl_out", 32'(want.scl_out), 32'(res.scl_out));
                check_field("sda_out", 32'(want.sda_out), 32'(res.sda_out));
                check_field("sda_drive", 32'(want.sda_drive), 32'(res.sda_drive));
                check_field("busy_res", 32'(want.busy_res), 32'(res.busy_res));
                check_field("done_res", 32'(want.done_res), 32'(res.done_res));
                check_field("read_data", 32'(want.read_data), 32'(res.read_data));
                check_field("ack_seen", 32'(want.ack_seen), 32'(res.ack_seen));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall) || psel)
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("i2c_master_byte_engine_core verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned random_base;
        int unsigned mode;
        logic [15:0] unit_pick;
        plan_rows = '{
            '{ROW_TICK, '{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 16'd0, 1'b1, RESET_PINS},
            '{ROW_TICK, '{1'b0, CMD_READ, 8'hFF, 1'b1, 1'b1}, 16'd0, 1'b1, RESET_PINS},
            '{ROW_SET_UNIT, '0, 16'd0, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_START, 8'hFF, 1'b1, 1'b1}, 16'd0, 1'b1, START_PINS},
            '{ROW_TICK, '{1'b1, CMD_WRITE, 8'hFF, 1'b1, 1'b0}, 16'd0, 1'b0, '0},
            '{ROW_DRAIN, '0, 16'd0, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_WRITE, 8'hFF, 1'b0, 1'b0}, 16'd0, 1'b0, '0},
            '{ROW_DRAIN, '0, 16'd0, 1'b0, '0},
            '{ROW_SET_UNIT, '0, 16'd1, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_WRITE, 8'h00, 1'b1, 1'b1}, 16'd0, 1'b0, '0},
            '{ROW_DRAIN, '0, 16'd0, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_READ, 8'h00, 1'b0, 1'b1}, 16'd0, 1'b0, '0},
            '{ROW_DRAIN, '0, 16'd0, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_READ, 8'hFF, 1'b1, 1'b0}, 16'd0, 1'b0, '0},
            '{ROW_DRAIN, '0, 16'd0, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_STOP, 8'h5A, 1'b0, 1'b0}, 16'd0, 1'b0, '0},
            '{ROW_DRAIN, '0, 16'd0, 1'b0, '0},
            '{ROW_SET_UNIT, '0, 16'd2, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_WRITE, 8'hA5, 1'b0, 1'b1}, 16'd0, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_READ, 8'h3C, 1'b1, 1'b0}, 16'd0, 1'b0, '0},
            '{ROW_DRAIN, '0, 16'd0, 1'b0, '0},
            '{ROW_TICK, '{1'b1, CMD_STOP, 8'h00, 1'b1, 1'b1}, 16'd0, 1'b0, '0},
            '{ROW_DRAIN, '0, 16'd0, 1'b0, '0}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[i])
        begin
            case (plan_rows[i].kind)
                ROW_TICK:     push_tick(plan_rows[i].tick, plan_rows[i].typed, plan_rows[i].want);
                ROW_SET_UNIT: set_unit_ticks(plan_rows[i].unit_ticks);
                default:      drain_command();
            endcase
        end

        random_base = ticks_sent;
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:       begin send_gap_pct = 17; recv_stall_pct = 59; end
                1:       begin send_gap_pct = 59; recv_stall_pct = 17; end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            while (ticks_sent - random_base < (mode + 1) * RANDOM_ITEMS / 3)
            begin
                case ($urandom_range(9))
                    0:       unit_pick = 16'd0;
                    1:       unit_pick = 16'd3;
                    2, 3:    unit_pick = 16'd2;
                    default: unit_pick = 16'd1;
                endcase
                set_unit_ticks(unit_pick);
                repeat (SEGMENT_ITEMS)
                    push_tick(noise_tick(seq_busy ? 10 : 80), 1'b0, '0);
                drain_command();
            end
        end

        // hold a start at the longest unit length; pins stay put throughout
        set_unit_ticks(16'hFFFF);
        push_tick('{1'b1, CMD_START, 8'h00, 1'b0, 1'b0}, 1'b0, '0);
        repeat (HOLD_ITEMS)
            push_tick(noise_tick(10), 1'b0, '0);

        req_valid <= 1'b0;
        while (pin_states_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_fields == 0)
            $display("i2c_master_byte_engine_core verification clean");
        else
            $display("i2c_master_byte_engine_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/i2cm_pkg.sv
src/i2cm_apb_regs.sv
src/i2cm_seq.sv
src/i2c_master_byte_engine_core.sv
src/i2cm_checker.sv
tb/sv/i2c_master_byte_engine_core_tb.sv
